// ----- design/pthc_pkg.sv -----
// pthc_pkg: types, register indexes and arithmetic helpers for the
// pressure/temperature/humidity compensation pipeline. No dependencies.
`default_nettype none
package pthc_pkg;

   localparam logic [2:0] REG_TEMP_CALIB   = 3'd0;
   localparam logic [2:0] REG_PRESS_FIRST  = 3'd1;
   localparam logic [2:0] REG_PRESS_SECOND = 3'd2;
   localparam logic [2:0] REG_PRESS_NINTH  = 3'd3;
   localparam logic [2:0] REG_HUM_CALIB    = 3'd4;

   localparam int unsigned DivSteps = 32;

   localparam logic [31:0] HumMax = 32'd419430400;

   typedef struct packed {
      logic [47:0] temp_calib;
      logic [63:0] press_calib_first;
      logic [63:0] press_calib_second;
      logic [15:0] press_calib_ninth;
      logic [63:0] hum_calib;
   } calib_type;

   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
      logic [15:0] raw_humidity;
   } sample_type;

   typedef struct packed {
      logic [31:0] temp;
      logic [16:0] hum;
      logic        err;
      logic        post;
   } carry_type;

   typedef struct packed {
      logic [31:0] num;
      logic [31:0] den;
      carry_type   car;
   } div_in_type;

   typedef struct packed {
      logic [31:0] quo;
      carry_type   car;
   } div_out_type;

   typedef struct packed {
      logic [31:0] temperature_centi;
      logic [31:0] pressure_pa;
      logic [16:0] humidity_q10;
      logic        divide_error;
   } result_type;

   function automatic logic [31:0] asr(input logic [31:0] x, input int s);
      logic signed [31:0] t;
      t = $signed(x) >>> s;
      return t;
   endfunction

   function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] r;
      r = a * b;
      return r;
   endfunction

   function automatic logic [31:0] sext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sext12(input logic [11:0] v);
      return {{20{v[11]}}, v};
   endfunction

   function automatic logic [31:0] sext8(input logic [7:0] v);
      return {{24{v[7]}}, v};
   endfunction

endpackage
`default_nettype wire

// ----- design/pthc_req_if.sv -----
// pthc_req_if: raw sample channel, valid/ready with three raw readings.
// No dependencies.
`default_nettype none
interface pthc_req_if;
   logic        valid;
   logic        ready;
   logic [19:0] raw_temperature;
   logic [19:0] raw_pressure;
   logic [15:0] raw_humidity;
   modport source(output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
   modport sink(input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface
`default_nettype wire

// ----- design/pthc_rsp_if.sv -----
// pthc_rsp_if: compensated result channel, valid/ready.
// No dependencies.
`default_nettype none
interface pthc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] temperature_centi;
   logic [31:0] pressure_pa;
   logic [16:0] humidity_q10;
   logic        divide_error;
   modport source(output valid, temperature_centi, pressure_pa, humidity_q10, divide_error,
                  input ready);
   modport sink(input valid, temperature_centi, pressure_pa, humidity_q10, divide_error,
                output ready);
endinterface
`default_nettype wire

// ----- design/pthc_csr_if.sv -----
// pthc_csr_if: calibration register write channel (index + data).
// No dependencies.
`default_nettype none
interface pthc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- design/pthc_front.sv -----
// pthc_front: ten-stage pipeline for temperature, pressure operands and humidity.
// Depends on pthc_pkg.
`default_nettype none
module pthc_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire logic                 in_valid,
   input  wire pthc_pkg::sample_type in_data,
   input  wire pthc_pkg::calib_type  calib,
   output logic                      out_valid,
   output pthc_pkg::div_in_type      out_data
);
   logic [10:1] vld_ff, vld_in;

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, h1, h2, h3, h4, h5, h6;
   always_comb begin
      t1 = {16'd0, calib.temp_calib[15:0]};
      t2 = pthc_pkg::sext16(calib.temp_calib[31:16]);
      t3 = pthc_pkg::sext16(calib.temp_calib[47:32]);
      p1 = {16'd0, calib.press_calib_first[15:0]};
      p2 = pthc_pkg::sext16(calib.press_calib_first[31:16]);
      p3 = pthc_pkg::sext16(calib.press_calib_first[47:32]);
      p4 = pthc_pkg::sext16(calib.press_calib_first[63:48]);
      p5 = pthc_pkg::sext16(calib.press_calib_second[15:0]);
      p6 = pthc_pkg::sext16(calib.press_calib_second[31:16]);
      h1 = {24'd0, calib.hum_calib[7:0]};
      h2 = pthc_pkg::sext16(calib.hum_calib[23:8]);
      h3 = {24'd0, calib.hum_calib[31:24]};
      h4 = pthc_pkg::sext12(calib.hum_calib[43:32]);
      h5 = pthc_pkg::sext12(calib.hum_calib[55:44]);
      h6 = pthc_pkg::sext8(calib.hum_calib[63:56]);
   end

   always_comb begin
      vld_in = {vld_ff[9:1], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // stage 1
   logic [31:0] adc_t, t_x, t_a;
   logic [31:0] s1_tp_ff, s1_aa_ff;
   logic [19:0] s1_adcp_ff;
   logic [15:0] s1_adch_ff;
   always_comb begin
      adc_t = {12'd0, in_data.raw_temperature};
      t_x   = (adc_t >> 3) - (t1 << 1);
      t_a   = (adc_t >> 4) - t1;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_tp_ff   <= pthc_pkg::mul(t_x, t2);
         s1_aa_ff   <= pthc_pkg::mul(t_a, t_a);
         s1_adcp_ff <= in_data.raw_pressure;
         s1_adch_ff <= in_data.raw_humidity;
      end
   end

   // stage 2
   logic [31:0] s2_v1_ff, s2_v2p_ff;
   logic [19:0] s2_adcp_ff;
   logic [15:0] s2_adch_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_v1_ff   <= pthc_pkg::asr(s1_tp_ff, 11);
         s2_v2p_ff  <= pthc_pkg::mul(pthc_pkg::asr(s1_aa_ff, 12), t3);
         s2_adcp_ff <= s1_adcp_ff;
         s2_adch_ff <= s1_adch_ff;
      end
   end

   // stage 3: t_fine
   logic [31:0] tf;
   logic [31:0] s3_temp_ff, s3_pv1_ff, s3_hh_ff;
   logic [19:0] s3_adcp_ff;
   logic [15:0] s3_adch_ff;
   always_comb begin
      tf = s2_v1_ff + pthc_pkg::asr(s2_v2p_ff, 14);
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s3_temp_ff <= pthc_pkg::asr(pthc_pkg::mul(tf, 32'd5) + 32'd128, 8);
         s3_pv1_ff  <= pthc_pkg::asr(tf, 1) - 32'd64000;
         s3_hh_ff   <= tf - 32'd76800;
         s3_adcp_ff <= s2_adcp_ff;
         s3_adch_ff <= s2_adch_ff;
      end
   end

   // stage 4
   logic [31:0] pa;
   logic [31:0] s4_sq_ff, s4_m5_ff, s4_m2_ff, s4_mh5_ff, s4_mh6_ff, s4_mh3_ff, s4_temp_ff;
   logic [19:0] s4_adcp_ff;
   logic [15:0] s4_adch_ff;
   always_comb begin
      pa = pthc_pkg::asr(s3_pv1_ff, 2);
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s4_sq_ff   <= pthc_pkg::mul(pa, pa);
         s4_m5_ff   <= pthc_pkg::mul(s3_pv1_ff, p5);
         s4_m2_ff   <= pthc_pkg::mul(p2, s3_pv1_ff);
         s4_mh5_ff  <= pthc_pkg::mul(h5, s3_hh_ff);
         s4_mh6_ff  <= pthc_pkg::mul(s3_hh_ff, h6);
         s4_mh3_ff  <= pthc_pkg::mul(s3_hh_ff, h3);
         s4_temp_ff <= s3_temp_ff;
         s4_adcp_ff <= s3_adcp_ff;
         s4_adch_ff <= s3_adch_ff;
      end
   end

   // stage 5
   logic [31:0] h_raw;
   logic [31:0] s5_v2a_ff, s5_m3_ff, s5_m5_ff, s5_m2_ff, s5_ha_ff, s5_bc_ff, s5_temp_ff;
   logic [19:0] s5_adcp_ff;
   always_comb begin
      h_raw = ({16'd0, s4_adch_ff} << 14) - (h4 << 20) - s4_mh5_ff + 32'd16384;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s5_v2a_ff  <= pthc_pkg::mul(pthc_pkg::asr(s4_sq_ff, 11), p6);
         s5_m3_ff   <= pthc_pkg::mul(p3, pthc_pkg::asr(s4_sq_ff, 13));
         s5_m5_ff   <= s4_m5_ff;
         s5_m2_ff   <= s4_m2_ff;
         s5_ha_ff   <= pthc_pkg::asr(h_raw, 15);
         s5_bc_ff   <= pthc_pkg::mul(pthc_pkg::asr(s4_mh6_ff, 10),
                                     pthc_pkg::asr(s4_mh3_ff, 11) + 32'd32768);
         s5_temp_ff <= s4_temp_ff;
         s5_adcp_ff <= s4_adcp_ff;
      end
   end

   // stage 6
   logic [31:0] s6_v2_ff, s6_v1_ff, s6_hm_ff, s6_ha_ff, s6_temp_ff;
   logic [19:0] s6_adcp_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         s6_v2_ff   <= pthc_pkg::asr(s5_v2a_ff + (s5_m5_ff << 1), 2) + (p4 << 16);
         s6_v1_ff   <= pthc_pkg::asr(pthc_pkg::asr(s5_m3_ff, 3) + pthc_pkg::asr(s5_m2_ff, 1),
                                     18);
         s6_hm_ff   <= pthc_pkg::mul(pthc_pkg::asr(s5_bc_ff, 10) + 32'd2097152, h2);
         s6_ha_ff   <= s5_ha_ff;
         s6_temp_ff <= s5_temp_ff;
         s6_adcp_ff <= s5_adcp_ff;
      end
   end

   // stage 7
   logic [31:0] pn_x;
   logic [31:0] s7_dp_ff, s7_pn_ff, s7_hp_ff, s7_temp_ff;
   always_comb begin
      pn_x = (32'd1048576 - {12'd0, s6_adcp_ff}) - pthc_pkg::asr(s6_v2_ff, 12);
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s7_dp_ff   <= pthc_pkg::mul(32'd32768 + s6_v1_ff, p1);
         s7_pn_ff   <= pthc_pkg::mul(pn_x, 32'd3125);
         s7_hp_ff   <= pthc_pkg::mul(s6_ha_ff, pthc_pkg::asr(s6_hm_ff + 32'd8192, 14));
         s7_temp_ff <= s6_temp_ff;
      end
   end

   // stage 8
   logic [31:0] ha2;
   logic [31:0] s8_den_ff, s8_pn_ff, s8_hp_ff, s8_aa_ff, s8_temp_ff;
   always_comb begin
      ha2 = pthc_pkg::asr(s7_hp_ff, 15);
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s8_den_ff  <= pthc_pkg::asr(s7_dp_ff, 15);
         s8_pn_ff   <= s7_pn_ff;
         s8_hp_ff   <= s7_hp_ff;
         s8_aa_ff   <= pthc_pkg::mul(ha2, ha2);
         s8_temp_ff <= s7_temp_ff;
      end
   end

   // stage 9
   logic [31:0] s9_den_ff, s9_pn_ff, s9_hp_ff, s9_x_ff, s9_temp_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         s9_x_ff    <= pthc_pkg::mul(pthc_pkg::asr(s8_aa_ff, 7), h1);
         s9_den_ff  <= s8_den_ff;
         s9_pn_ff   <= s8_pn_ff;
         s9_hp_ff   <= s8_hp_ff;
         s9_temp_ff <= s8_temp_ff;
      end
   end

   // stage 10: humidity clamp, divide operands
   logic [31:0]          hv, hc;
   pthc_pkg::div_in_type s10_in, s10_ff;
   always_comb begin
      hv = s9_hp_ff - pthc_pkg::asr(s9_x_ff, 4);
      if (hv[31]) begin
         hc = '0;
      end else if (hv > pthc_pkg::HumMax) begin
         hc = pthc_pkg::HumMax;
      end else begin
         hc = hv;
      end
      s10_in.den      = s9_den_ff;
      s10_in.num      = s9_pn_ff[31] ? s9_pn_ff : (s9_pn_ff << 1);
      s10_in.car.post = s9_pn_ff[31];
      s10_in.car.err  = (s9_den_ff == '0);
      s10_in.car.temp = s9_temp_ff;
      s10_in.car.hum  = hc[28:12];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s10_ff <= s10_in;
      end
   end

   assign out_valid = vld_ff[10];
   assign out_data  = s10_ff;
endmodule
`default_nettype wire

// ----- design/pthc_divider.sv -----
// pthc_divider: pipelined restoring divider, one quotient bit per stage.
// Depends on pthc_pkg.
`default_nettype none
module pthc_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire logic                 in_valid,
   input  wire pthc_pkg::div_in_type in_data,
   output logic                      out_valid,
   output pthc_pkg::div_out_type     out_data
);
   localparam int unsigned N = pthc_pkg::DivSteps;

   logic                   vld_ff [N+1];
   logic [31:0]            num_ff [N+1];
   logic [31:0]            den_ff [N+1];
   logic [31:0]            rem_ff [N+1];
   logic [31:0]            quo_ff [N+1];
   pthc_pkg::carry_type    car_ff [N+1];

   always_comb begin
      vld_ff[0] = in_valid;
      num_ff[0] = in_data.num;
      den_ff[0] = in_data.den;
      rem_ff[0] = '0;
      quo_ff[0] = '0;
      car_ff[0] = in_data.car;
   end

   for (genvar k = 0; k < N; k++) begin : g_step
      logic [32:0] trial, diff;
      logic        take;
      always_comb begin
         trial = {rem_ff[k], num_ff[k][31]};
         diff  = trial - {1'b0, den_ff[k]};
         take  = !diff[32];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            num_ff[k+1] <= num_ff[k] << 1;
            den_ff[k+1] <= den_ff[k];
            rem_ff[k+1] <= take ? diff[31:0] : trial[31:0];
            quo_ff[k+1] <= {quo_ff[k][30:0], take};
            car_ff[k+1] <= car_ff[k];
         end
      end
   end

   assign out_valid    = vld_ff[N];
   assign out_data.quo = quo_ff[N];
   assign out_data.car = car_ff[N];
endmodule
`default_nettype wire

// ----- design/pthc_back.sv -----
// pthc_back: three-stage pressure correction and result register.
// Depends on pthc_pkg.
`default_nettype none
module pthc_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire logic                  in_valid,
   input  wire pthc_pkg::div_out_type in_data,
   input  wire pthc_pkg::calib_type   calib,
   output logic                       out_valid,
   output pthc_pkg::result_type       out_data
);
   logic [31:0] p7, p8, p9, p;
   logic [3:1]  vld_ff;

   always_comb begin
      p7 = pthc_pkg::sext16(calib.press_calib_second[47:32]);
      p8 = pthc_pkg::sext16(calib.press_calib_second[63:48]);
      p9 = pthc_pkg::sext16(calib.press_calib_ninth);
      p  = in_data.car.post ? (in_data.quo << 1) : in_data.quo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[2:1], in_valid};
      end
   end

   logic [31:0]         s1_p_ff, s1_sq_ff, s1_m8_ff;
   pthc_pkg::carry_type s1_car_ff, s2_car_ff;
   logic [31:0]         s2_p_ff, s2_a_ff, s2_m8_ff;
   logic [31:0]         corr, pf;
   pthc_pkg::result_type res_in, res_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_p_ff   <= p;
         s1_sq_ff  <= pthc_pkg::mul(p >> 3, p >> 3);
         s1_m8_ff  <= pthc_pkg::mul(p >> 2, p8);
         s1_car_ff <= in_data.car;
         s2_p_ff   <= s1_p_ff;
         s2_a_ff   <= pthc_pkg::mul(p9, s1_sq_ff >> 13);
         s2_m8_ff  <= s1_m8_ff;
         s2_car_ff <= s1_car_ff;
         res_ff    <= res_in;
      end
   end

   always_comb begin
      corr = pthc_pkg::asr(s2_a_ff, 12) + pthc_pkg::asr(s2_m8_ff, 13) + p7;
      pf   = s2_p_ff + pthc_pkg::asr(corr, 4);
      res_in.temperature_centi = s2_car_ff.temp;
      res_in.divide_error      = s2_car_ff.err;
      res_in.pressure_pa       = s2_car_ff.err ? '0 : pf;
      res_in.humidity_q10      = s2_car_ff.err ? '0 : s2_car_ff.hum;
   end

   assign out_valid = vld_ff[3];
   assign out_data  = res_ff;
endmodule
`default_nettype wire

// ----- design/pth_sensor_compensation.sv -----
// pth_sensor_compensation: top level, calibration registers and pipeline.
// The pipeline has 10 front stages, 32 divider stages (one quotient bit
// each) and 3 back stages ending in the result register. Throughput one
// sample per cycle; the whole pipeline holds while a result waits.
// Synchronous active-high reset clears valid bits and calibration to 0.
// Depends on pthc_pkg, the pthc_*_if interfaces, pthc_front/divider/back.
`default_nettype none
module pth_sensor_compensation (
   input  wire logic   clock,
   input  wire logic   reset,
   pthc_req_if.sink    req_chan,
   pthc_rsp_if.source  rsp_chan,
   pthc_csr_if.sink    csr_chan
);
   pthc_pkg::calib_type  calib_ff;
   pthc_pkg::sample_type sample;
   pthc_pkg::div_in_type front_data;
   pthc_pkg::div_out_type div_data;
   pthc_pkg::result_type res;
   logic adv, front_valid, div_valid, res_valid;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_ff <= '0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            pthc_pkg::REG_TEMP_CALIB:   calib_ff.temp_calib         <= csr_chan.data[47:0];
            pthc_pkg::REG_PRESS_FIRST:  calib_ff.press_calib_first  <= csr_chan.data;
            pthc_pkg::REG_PRESS_SECOND: calib_ff.press_calib_second <= csr_chan.data;
            pthc_pkg::REG_PRESS_NINTH:  calib_ff.press_calib_ninth  <= csr_chan.data[15:0];
            pthc_pkg::REG_HUM_CALIB:    calib_ff.hum_calib          <= csr_chan.data;
            default: ;
         endcase
      end
   end

   assign adv            = !res_valid || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_comb begin
      sample.raw_temperature = req_chan.raw_temperature;
      sample.raw_pressure    = req_chan.raw_pressure;
      sample.raw_humidity    = req_chan.raw_humidity;
   end

   pthc_front u_front (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(req_chan.valid), .in_data(sample), .calib(calib_ff),
      .out_valid(front_valid), .out_data(front_data)
   );

   pthc_divider u_div (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(front_valid), .in_data(front_data),
      .out_valid(div_valid), .out_data(div_data)
   );

   pthc_back u_back (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(div_valid), .in_data(div_data), .calib(calib_ff),
      .out_valid(res_valid), .out_data(res)
   );

   assign rsp_chan.valid             = res_valid;
   assign rsp_chan.temperature_centi = res.temperature_centi;
   assign rsp_chan.pressure_pa       = res.pressure_pa;
   assign rsp_chan.humidity_q10      = res.humidity_q10;
   assign rsp_chan.divide_error      = res.divide_error;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.divide_error |->
         rsp_chan.pressure_pa == '0 && rsp_chan.humidity_q10 == '0)
      else $error("divide error result not zeroed");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.humidity_q10 <= 17'd102400)
      else $error("humidity out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid && !div_valid && !front_valid)
      else $error("pipeline not empty after reset");
endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// tb_top: directed and random test of pth_sensor_compensation against a built-in predictor.
// Depends on pth_sensor_compensation, pthc_pkg and the pthc_*_if interfaces.
`default_nettype none
module tb_top;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   pthc_req_if req_chan ();
   pthc_rsp_if rsp_chan ();
   pthc_csr_if csr_chan ();

   pth_sensor_compensation dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   int unsigned mismatches = 0;
   int unsigned cycles = 0;
   bit          calm = 1'b0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
      mismatches++;
   endtask

   function automatic logic [31:0] sra(input logic [31:0] x, input int s);
      return $unsigned($signed(x) >>> s);
   endfunction

   function automatic logic [31:0] sx(input logic [31:0] v, input int bits);
      logic [31:0] m;
      m = (bits == 32) ? 32'hffffffff : ((32'd1 << bits) - 1);
      return ((v & m) ^ (32'd1 << (bits - 1))) - (32'd1 << (bits - 1));
   endfunction

   class compensation_scoreboard;
      pthc_pkg::calib_type   cal;
      pthc_pkg::result_type  pending[$];

      function void note_sample(input pthc_pkg::sample_type s);
         logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
         logic [31:0] h1, h2, h3, h4, h5, h6;
         logic [31:0] a, b, v1, v2, tf, p, sq, h;
         pthc_pkg::result_type r;
         t1 = 32'(cal.temp_calib[15:0]);
         t2 = sx(32'(cal.temp_calib[31:16]), 16);
         t3 = sx(32'(cal.temp_calib[47:32]), 16);
         p1 = 32'(cal.press_calib_first[15:0]);
         p2 = sx(32'(cal.press_calib_first[31:16]), 16);
         p3 = sx(32'(cal.press_calib_first[47:32]), 16);
         p4 = sx(32'(cal.press_calib_first[63:48]), 16);
         p5 = sx(32'(cal.press_calib_second[15:0]), 16);
         p6 = sx(32'(cal.press_calib_second[31:16]), 16);
         p7 = sx(32'(cal.press_calib_second[47:32]), 16);
         p8 = sx(32'(cal.press_calib_second[63:48]), 16);
         p9 = sx(32'(cal.press_calib_ninth), 16);
         h1 = 32'(cal.hum_calib[7:0]);
         h2 = sx(32'(cal.hum_calib[23:8]), 16);
         h3 = 32'(cal.hum_calib[31:24]);
         h4 = sx(32'(cal.hum_calib[43:32]), 12);
         h5 = sx(32'(cal.hum_calib[55:44]), 12);
         h6 = sx(32'(cal.hum_calib[63:56]), 8);
         r = '0;
         v1 = sra(((32'(s.raw_temperature) >> 3) - (t1 << 1)) * t2, 11);
         a = (32'(s.raw_temperature) >> 4) - t1;
         v2 = sra(sra(a * a, 12) * t3, 14);
         tf = v1 + v2;
         r.temperature_centi = sra(tf * 32'd5 + 32'd128, 8);
         v1 = sra(tf, 1) - 32'd64000;
         a = sra(v1, 2);
         sq = a * a;
         v2 = sra(sq, 11) * p6;
         v2 = v2 + ((v1 * p5) << 1);
         v2 = sra(v2, 2) + (p4 << 16);
         v1 = sra(sra(p3 * sra(sq, 13), 3) + sra(p2 * v1, 1), 18);
         v1 = sra((32'd32768 + v1) * p1, 15);
         if (v1 == 0) begin
            r.divide_error = 1'b1;
         end else begin
            p = ((32'd1048576 - 32'(s.raw_pressure)) - sra(v2, 12)) * 32'd3125;
            if (p < 32'h80000000) p = (p << 1) / v1;
            else p = (p / v1) * 32'd2;
            a = p9 * (((p >> 3) * (p >> 3)) >> 13);
            v1 = sra(a, 12);
            v2 = sra((p >> 2) * p8, 13);
            p = p + sra(v1 + v2 + p7, 4);
            r.pressure_pa = p;
            h = tf - 32'd76800;
            a = sra((32'(s.raw_humidity) << 14) - (h4 << 20) - h5 * h + 32'd16384, 15);
            b = sra(h * h6, 10);
            b = sra(b * (sra(h * h3, 11) + 32'd32768), 10) + 32'd2097152;
            b = sra(b * h2 + 32'd8192, 14);
            h = a * b;
            a = sra(h, 15);
            h = h - sra(sra(a * a, 7) * h1, 4);
            if (h[31]) h = 0;
            if (h > 32'd419430400) h = 32'd419430400;
            r.humidity_q10 = 17'(h >> 12);
         end
         pending.push_back(r);
      endfunction

      task check_result(input pthc_pkg::result_type got);
         pthc_pkg::result_type w;
         if (pending.size() == 0) begin
            report("unexpected transfer", got.pressure_pa, 0);
            return;
         end
         w = pending.pop_front();
         if (got.temperature_centi !== w.temperature_centi)
            report("temperature_centi", got.temperature_centi, w.temperature_centi);
         if (got.pressure_pa !== w.pressure_pa)
            report("pressure_pa", got.pressure_pa, w.pressure_pa);
         if (got.humidity_q10 !== w.humidity_q10)
            report("humidity_q10", 32'(got.humidity_q10), 32'(w.humidity_q10));
         if (got.divide_error !== w.divide_error)
            report("divide_error", 32'(got.divide_error), 32'(w.divide_error));
      endtask
   endclass

   compensation_scoreboard board = new();

   initial begin
      req_chan.valid = 1'b0;
      req_chan.raw_temperature = '0;
      req_chan.raw_pressure = '0;
      req_chan.raw_humidity = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data = '0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= calm || ($urandom_range(99) >= 18);
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.check_result('{rsp_chan.temperature_centi, rsp_chan.pressure_pa,
                              rsp_chan.humidity_q10, rsp_chan.divide_error});
   end

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= val;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         pthc_pkg::REG_TEMP_CALIB:   board.cal.temp_calib = val[47:0];
         pthc_pkg::REG_PRESS_FIRST:  board.cal.press_calib_first = val;
         pthc_pkg::REG_PRESS_SECOND: board.cal.press_calib_second = val;
         pthc_pkg::REG_PRESS_NINTH:  board.cal.press_calib_ninth = val[15:0];
         pthc_pkg::REG_HUM_CALIB:    board.cal.hum_calib = val;
         default: ;
      endcase
   endtask

   task automatic send(input logic [19:0] t, input logic [19:0] p, input logic [15:0] h);
      pthc_pkg::sample_type s;
      while (!calm && $urandom_range(99) < 18) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      s = '{t, p, h};
      req_chan.valid <= 1'b1;
      req_chan.raw_temperature <= t;
      req_chan.raw_pressure <= p;
      req_chan.raw_humidity <= h;
      do @(posedge clock); while (!req_chan.ready);
      board.note_sample(s);
   endtask

   task automatic drain();
      int unsigned n;
      n = 0;
      req_chan.valid <= 1'b0;
      while (board.pending.size() != 0 && n < 20000) begin
         @(posedge clock);
         n++;
      end
   endtask

   // zero, typical factory, all-ones, extreme or random calibration, by mode
   task automatic load_calib(input int mode);
      logic [63:0] v[5];
      case (mode)
         0: v = '{64'h0, 64'h0, 64'h0, 64'h0, 64'h0};
         1: v = '{{16'h0, 16'hfc18, 16'h6684, 16'h6f80},
                  {16'h2b0c, 16'h0bd0, 16'hd6f0, 16'h8e58},
                  {16'hc7a6, 16'h03b5, 16'hfff9, 16'hffca},
                  64'h1770,
                  {8'h1e, 12'h032, 12'h14c, 8'h00, 16'h016a, 8'h4b}};
         2: v = '{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                  64'hffff_ffff_ffff_ffff, 64'hffff, 64'hffff_ffff_ffff_ffff};
         3: v = '{{16'h0, 16'h8000, 16'h8000, 16'h0001},
                  {16'h7fff, 16'h7fff, 16'h8000, 16'hffff},
                  {16'h8000, 16'h7fff, 16'h8000, 16'h7fff},
                  64'h8000,
                  {8'h80, 12'h800, 12'h7ff, 8'hff, 16'h7fff, 8'hff}};
         default: v = '{{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom}, {$urandom, $urandom}};
      endcase
      for (int i = 0; i < 5; i++) write_reg(i[2:0], v[i]);
      write_reg(3'd7, {$urandom, $urandom});
      csr_chan.valid <= 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: zero calibration divides by zero
      send(20'h0, 20'h0, 16'h0);
      send(20'hfffff, 20'hfffff, 16'hffff);
      drain();
      load_calib(1);
      send(20'h7e1e0, 20'h5a3c0, 16'h6a40);
      send(20'h0, 20'h0, 16'h0);
      send(20'hfffff, 20'hfffff, 16'hffff);
      send(20'h80000, 20'h0, 16'hffff);
      send(20'h0, 20'hfffff, 16'h0);
      send(20'h55555, 20'haaaaa, 16'h5555);
      send(20'haaaaa, 20'h55555, 16'haaaa);
      for (int m = 2; m < 10; m++) begin
         drain();
         repeat (60) @(posedge clock);
         load_calib(m);
         calm = (m == 5);
         for (int k = 0; k < 150; k++) begin
            if (m >= 4 || $urandom_range(3) == 0)
               send($urandom, $urandom, $urandom);
            else
               send(20'h60000 + $urandom_range(20'h3ffff), 20'h40000 + $urandom_range(20'h3ffff),
                    16'h4000 + $urandom_range(16'h7fff));
         end
      end
      calm = 1'b0;
      drain();
      repeat (60) @(posedge clock);
      if (mismatches == 0 && board.pending.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ----- filelist.f -----
design/pthc_pkg.sv
design/pthc_req_if.sv
design/pthc_rsp_if.sv
design/pthc_csr_if.sv
design/pthc_front.sv
design/pthc_divider.sv
design/pthc_back.sv
design/pth_sensor_compensation.sv
test/tb_top.sv
